// File: design/text_escape_line_numberer_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text escape line numberer core
// Each macro expects clk and rst in scope and checks only outside reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_ESCAPE_LINE_NUMBERER_CORE_ASSERT_SVH
`define TEXT_ESCAPE_LINE_NUMBERER_CORE_ASSERT_SVH

// Check a condition at every edge
`define TELN_CHECK(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("teln check failed");

// Check that pre implies post in the same cycle
`define TELN_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("teln implication failed");

// Check that pre implies post in the next cycle
`define TELN_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("teln next-cycle check failed");

`endif

// File: design/teln_pkg.sv
// ---------------------------------------------------------------------------
// teln_pkg
// Types, character codes and register indexes shared by the line numberer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package teln_pkg;

  localparam int LINE_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int BODY_BYTES      = 4;
  localparam int BODY_LEN_W      = 3;
  localparam int CFG_INDEX_W     = 3;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CTRL_BIAS = 8'h40;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_LINES         = 3'd0,
    REG_NUMBER_NONBLANK_ONLY = 3'd1,
    REG_SHOW_LINE_ENDS       = 3'd2,
    REG_SQUEEZE_BLANK_LINES  = 3'd3,
    REG_SHOW_TABS            = 3'd4,
    REG_SHOW_NONPRINTING     = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic number_lines;
    logic number_nonblank_only;
    logic show_line_ends;
    logic squeeze_blank_lines;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // Body bytes of one input beat, in emit order, plus the number prefix flag
  typedef struct packed {
    logic                             has_num;
    logic [BODY_LEN_W-1:0]            body_len;
    logic [BODY_BYTES-1:0][7:0]       body;
  } job_t;

endpackage

// File: design/teln_queue.sv
// ---------------------------------------------------------------------------
// teln_queue
// Small register queue that carries classified jobs from front to back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module teln_queue import teln_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/teln_front.sv
// ---------------------------------------------------------------------------
// teln_front
// Accept input beats, track line state and counter, classify into jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module teln_front import teln_pkg::*; #(
  parameter int LINE_DIGITS = LINE_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       push,
  input  in_item_t                   in_data,
  input  logic                       q_full,
  output logic                       q_wr_en,
  output job_t                       q_job,
  output logic [4*LINE_DIGITS-1:0]   q_bcd
);

  localparam int BW = 4 * LINE_DIGITS;

  logic          after_newline;
  logic          after_newline_next;
  logic          squeezing;
  logic          squeezing_next;
  logic [BW-1:0] line_bcd;
  logic [BW-1:0] line_bcd_next;

  logic          accept;
  logic          an;
  logic          sq;
  logic [BW-1:0] bcd_cur;
  logic [BW-1:0] bcd_inc;
  logic          is_nl;
  logic          squeeze_hit;
  logic          use_num;
  logic          emit;
  logic [7:0]    ch;
  logic [6:0]    low7;
  logic          is_ctrl;
  logic [7:0]    e0;
  logic [7:0]    e1;
  logic [1:0]    elen;
  logic          all_nines;
  logic          carry;
  job_t          job;

  assign accept = push && !q_full;
  assign ch     = in_data.data_byte;
  assign is_nl  = (ch == CH_NL);
  assign an      = in_data.new_file ? 1'b1 : after_newline;
  assign sq      = in_data.new_file ? 1'b0 : squeezing;
  assign bcd_cur = in_data.new_file ? '0 : line_bcd;

  // Saturating BCD increment
  always_comb begin
    all_nines = 1'b1;
    carry     = 1'b1;
    bcd_inc   = bcd_cur;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (bcd_cur[4*i +: 4] != 4'd9) begin
        all_nines = 1'b0;
      end
    end
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (carry) begin
        if (bcd_cur[4*i +: 4] >= 4'd9) begin
          bcd_inc[4*i +: 4] = 4'd0;
        end else begin
          bcd_inc[4*i +: 4] = bcd_cur[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all_nines) begin
      bcd_inc = bcd_cur;
    end
  end

  assign squeeze_hit = an && is_nl && cfg.squeeze_blank_lines;
  assign use_num     = an && cfg.number_lines && (!is_nl || !cfg.number_nonblank_only);
  assign emit        = !squeeze_hit || !sq;

  // Escape form of the low seven bits
  assign low7    = ch[6:0];
  assign is_ctrl = ({1'b0, low7} < CTRL_TOP) || ({1'b0, low7} == CH_DEL);

  always_comb begin
    if (is_ctrl) begin
      e0   = CH_CARET;
      e1   = ({1'b0, low7} == CH_DEL) ? CH_QMARK : ({1'b0, low7} | CTRL_BIAS);
      elen = 2'd2;
    end else begin
      e0   = {1'b0, low7};
      e1   = '0;
      elen = 2'd1;
    end
  end

  always_comb begin
    job          = '0;
    job.has_num  = use_num && !squeeze_hit;
    job.body_len = BODY_LEN_W'(1);
    job.body[0]  = ch;
    if (squeeze_hit) begin
      job.body[0] = CH_NL;
    end else if (is_nl) begin
      if (cfg.show_line_ends) begin
        job.body[0]  = CH_DOLLAR;
        job.body[1]  = CH_NL;
        job.body_len = BODY_LEN_W'(2);
      end
    end else if (ch == CH_TAB) begin
      if (cfg.show_tabs) begin
        job.body[0]  = CH_CARET;
        job.body[1]  = CH_I;
        job.body_len = BODY_LEN_W'(2);
      end
    end else if (cfg.show_nonprinting) begin
      if (ch[7]) begin
        job.body[0]  = CH_M;
        job.body[1]  = CH_DASH;
        job.body[2]  = e0;
        job.body[3]  = e1;
        job.body_len = BODY_LEN_W'(2) + BODY_LEN_W'(elen);
      end else begin
        job.body[0]  = e0;
        job.body[1]  = e1;
        job.body_len = BODY_LEN_W'(elen);
      end
    end
  end

  always_comb begin
    after_newline_next = after_newline;
    squeezing_next     = squeezing;
    line_bcd_next      = line_bcd;
    if (accept) begin
      if (squeeze_hit) begin
        after_newline_next = 1'b1;
        squeezing_next     = 1'b1;
        line_bcd_next      = bcd_cur;
      end else begin
        after_newline_next = is_nl;
        squeezing_next     = 1'b0;
        line_bcd_next      = use_num ? bcd_inc : bcd_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_newline <= 1'b1;
      squeezing     <= 1'b0;
      line_bcd      <= '0;
    end else begin
      after_newline <= after_newline_next;
      squeezing     <= squeezing_next;
      line_bcd      <= line_bcd_next;
    end
  end

  assign q_wr_en = accept && emit;
  assign q_job   = job;
  assign q_bcd   = bcd_inc;

endmodule

// File: design/teln_back.sv
// ---------------------------------------------------------------------------
// teln_back
// Expand queued jobs into output register bytes, one per cycle unless pop stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_escape_line_numberer_core_assert.svh"

module teln_back import teln_pkg::*; #(
  parameter int LINE_DIGITS = LINE_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  job_t                     q_job,
  input  logic [4*LINE_DIGITS-1:0] q_bcd,
  output logic                     q_rd_en,
  output logic                     empty,
  input  logic                     pop,
  output out_item_t                out_data
);

  localparam int CW = $clog2(LINE_DIGITS + 6);

  logic            out_valid;
  out_item_t       out_reg;
  logic [CW-1:0]   cnt;

  logic            job_valid;
  logic            load;
  logic            last;
  logic [CW-1:0]   total_len;
  logic [CW-1:0]   body_idx;
  logic [7:0]      byte_sel;
  logic [7:0]      digit_char;
  logic            zero_above;
  logic [3:0]      d;
  logic [LINE_DIGITS-1:0][7:0] digit_bytes;

  assign job_valid = !q_empty;
  assign total_len = q_job.has_num ? CW'(LINE_DIGITS + 1) + CW'(q_job.body_len)
                                   : CW'(q_job.body_len);
  assign last      = (cnt == total_len - 1'b1);
  assign load      = job_valid && (!out_valid || pop);
  assign q_rd_en   = load && last;
  assign body_idx  = q_job.has_num ? cnt - CW'(LINE_DIGITS + 1) : cnt;

  // Blank leading zeros, keep the units digit
  always_comb begin
    zero_above  = 1'b1;
    digit_bytes = '0;
    d           = '0;
    for (int k = LINE_DIGITS - 1; k >= 0; k--) begin
      d = (q_bcd[4*k +: 4] > 4'd9) ? 4'd9 : q_bcd[4*k +: 4];
      zero_above = zero_above && (d == 4'd0);
      digit_bytes[k] = (zero_above && k != 0) ? CH_SPACE : (CH_ZERO | {4'd0, d});
    end
  end

  always_comb begin
    digit_char = CH_SPACE;
    for (int k = 0; k < LINE_DIGITS; k++) begin
      if (cnt == CW'(LINE_DIGITS - 1 - k)) begin
        digit_char = digit_bytes[k];
      end
    end
  end

  always_comb begin
    if (q_job.has_num && cnt < CW'(LINE_DIGITS)) begin
      byte_sel = digit_char;
    end else if (q_job.has_num && cnt == CW'(LINE_DIGITS)) begin
      byte_sel = CH_TAB;
    end else begin
      byte_sel = q_job.body[body_idx[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg.out_byte    <= byte_sel;
      out_reg.last_of_run <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= last ? '0 : cnt + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid;
  assign out_data = out_reg;

  `TELN_IMPLIES(a_cnt_in_range, job_valid, cnt < total_len)
  `TELN_IMPLIES(a_cnt_idle_zero, !job_valid, cnt == '0)
  `TELN_NEXT(a_last_restarts, load && last, cnt == '0 && out_valid && out_data.last_of_run)

endmodule

// File: design/text_escape_line_numberer_core.sv
// Result bytes pass through the job queue and then the output register.
// Throughput: one input beat per cycle while the job queue has room; the expander
// emits one byte per cycle while its output register is empty or being popped.
// A QUEUE_DEPTH job queue parts the classifier from the expander.
// Reset (rst, synchronous): registers to 0, line state to line start, counter to 0,
// queue and output register empty; no clearing pass.
// ---------------------------------------------------------------------------
// text_escape_line_numberer_core
// Line numbering, blank-line squeezing and escaping of a text byte stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_escape_line_numberer_core import teln_pkg::*; #(
  parameter int LINE_DIGITS = LINE_DIGITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic                   wr_data,
  input  logic                   push,
  output logic                   full,
  input  in_item_t               in_data,
  output logic                   empty,
  input  logic                   pop,
  output out_item_t              out_data
);

  localparam int BW = 4 * LINE_DIGITS;
  localparam int QW = BW + $bits(job_t);

  cfg_t          cfg;
  logic          q_wr_en;
  job_t          f_job;
  logic [BW-1:0] f_bcd;
  logic          q_full;
  logic          q_rd_en;
  logic          q_empty;
  logic [QW-1:0] q_rd_data;
  job_t          b_job;
  logic [BW-1:0] b_bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_NUMBER_LINES:         cfg.number_lines         <= wr_data;
        REG_NUMBER_NONBLANK_ONLY: cfg.number_nonblank_only <= wr_data;
        REG_SHOW_LINE_ENDS:       cfg.show_line_ends       <= wr_data;
        REG_SQUEEZE_BLANK_LINES:  cfg.squeeze_blank_lines  <= wr_data;
        REG_SHOW_TABS:            cfg.show_tabs            <= wr_data;
        REG_SHOW_NONPRINTING:     cfg.show_nonprinting     <= wr_data;
        default:                  cfg                      <= cfg;
      endcase
    end
  end

  teln_front #(
    .LINE_DIGITS(LINE_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_wr_en (q_wr_en),
    .q_job   (f_job),
    .q_bcd   (f_bcd)
  );

  teln_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data ({f_bcd, f_job}),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign b_bcd = q_rd_data[QW-1 -: BW];
  assign b_job = job_t'(q_rd_data[$bits(job_t)-1:0]);

  teln_back #(
    .LINE_DIGITS(LINE_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_job    (b_job),
    .q_bcd    (b_bcd),
    .q_rd_en  (q_rd_en),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  assign full = q_full;

endmodule
